/* hw/rtl/chbd_pkg.sv */
// Shared types and constants for the chunked body decoder.
// Depends on nothing; imported by every module of the block.
package chbd_pkg;

   // Width of the chunk size register; a size that needs more bits is an overflow.
   localparam int SIZE_BITS = 32;
   localparam int LEN_BITS  = 32;

   localparam logic [7:0] CH_0  = 8'h30;
   localparam logic [7:0] CH_9  = 8'h39;
   localparam logic [7:0] CH_LA = 8'h61;
   localparam logic [7:0] CH_LF_HEX = 8'h66;
   localparam logic [7:0] CH_UA = 8'h41;
   localparam logic [7:0] CH_UF = 8'h46;
   localparam logic [7:0] CH_CR = 8'h0d;
   localparam logic [7:0] CH_LF = 8'h0a;

   localparam logic [3:0] DIGIT_SAT = 4'd15;

   typedef enum logic [5:0] {
      M_SIZE  = 6'b000001,
      M_SKIP  = 6'b000010,
      M_DATA  = 6'b000100,
      M_AFTD  = 6'b001000,
      M_AFTCR = 6'b010000,
      M_DONE  = 6'b100000
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_TRUNC = 2'd1,
      ST_OVF   = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0]          out_byte;
      logic                byte_valid;
      logic                msg_end;
      logic [1:0]          status;
      logic [LEN_BITS-1:0] payload_len;
   } rsp_type;

   // Parser context carried from one byte to the next.
   typedef struct packed {
      mode_type             mode;
      logic [SIZE_BITS-1:0] remaining;
      logic [3:0]           digits;
      logic [LEN_BITS-1:0]  count;
   } ctx_type;

   localparam ctx_type CTX_RESET = '{
      mode:      M_SIZE,
      remaining: '0,
      digits:    '0,
      count:     '0
   };

endpackage

/* hw/rtl/chbd_step.sv */
// Next-state and result logic for one body byte of the chunked decoder.
// Depends on chbd_pkg.
module chbd_step
   import chbd_pkg::*;
(
   input  ctx_type cur,
   input  req_type item,
   output ctx_type nxt,
   output logic    emit,
   output rsp_type rsp
);

   typedef struct packed {
      mode_type             mode;
      logic [SIZE_BITS-1:0] remaining;
      logic [3:0]           digits;
      logic                 fin;
      status_type           st;
   } sz_type;

   // One byte of a size line: LF closes the line, a hex digit shifts in,
   // anything else starts the skip to end of line.
   function automatic sz_type size_byte(input logic [7:0] c,
                                        input logic [SIZE_BITS-1:0] rem,
                                        input logic [3:0] dig);
      sz_type     r;
      logic       is_hex;
      logic [3:0] v;
      r.mode      = M_SIZE;
      r.remaining = rem;
      r.digits    = dig;
      r.fin       = 1'b0;
      r.st        = ST_OK;
      is_hex      = 1'b1;
      v           = '0;
      case (c) inside
         [CH_0:CH_9]:       v = c[3:0];
         [CH_LA:CH_LF_HEX]: v = c[3:0] + 4'd9;
         [CH_UA:CH_UF]:     v = c[3:0] + 4'd9;
         default:           is_hex = 1'b0;
      endcase
      if (c == CH_LF) begin
         if (rem == '0) begin
            r.fin  = 1'b1;
            r.mode = M_DONE;
         end else begin
            r.mode = M_DATA;
         end
      end else if (is_hex) begin
         if (rem[SIZE_BITS-1 -: 4] != 4'd0) begin
            r.fin  = 1'b1;
            r.st   = ST_OVF;
            r.mode = M_DONE;
         end else begin
            r.remaining = {rem[SIZE_BITS-5:0], v};
            if (dig < DIGIT_SAT) r.digits = dig + 4'd1;
         end
      end else begin
         r.mode = M_SKIP;
      end
      return r;
   endfunction

   sz_type               sz;
   ctx_type              stepped;
   logic                 fin;
   logic                 was_done;
   logic                 valid;
   status_type           st;
   logic [SIZE_BITS-1:0] rem_dec;

   assign rem_dec = cur.remaining - {{(SIZE_BITS-1){1'b0}}, 1'b1};

   always_comb begin
      stepped  = cur;
      fin      = 1'b0;
      was_done = 1'b0;
      valid    = 1'b0;
      st       = ST_OK;
      sz       = size_byte(item.in_byte, cur.remaining, cur.digits);
      case (cur.mode)
         M_SIZE: begin
            stepped.mode      = sz.mode;
            stepped.remaining = sz.remaining;
            stepped.digits    = sz.digits;
            fin               = sz.fin;
            st                = sz.st;
         end
         M_SKIP: begin
            if (item.in_byte == CH_LF) begin
               sz           = size_byte(CH_LF, cur.remaining, cur.digits);
               stepped.mode = sz.mode;
               fin          = sz.fin;
               st           = sz.st;
            end
         end
         M_DATA: begin
            valid             = 1'b1;
            stepped.count     = cur.count + {{(LEN_BITS-1){1'b0}}, 1'b1};
            stepped.remaining = rem_dec;
            if (rem_dec == '0) stepped.mode = M_AFTD;
         end
         M_AFTD, M_AFTCR: begin
            if (cur.mode == M_AFTD && item.in_byte == CH_CR) begin
               stepped.mode = M_AFTCR;
            end else if (item.in_byte == CH_LF) begin
               stepped.mode      = M_SIZE;
               stepped.remaining = '0;
               stepped.digits    = '0;
            end else begin
               // no line end after data: byte opens the next size line
               sz                = size_byte(item.in_byte, '0, '0);
               stepped.mode      = sz.mode;
               stepped.remaining = sz.remaining;
               stepped.digits    = sz.digits;
               fin               = sz.fin;
               st                = sz.st;
            end
         end
         default: was_done = 1'b1;
      endcase

      if (item.in_last && !fin && !was_done) begin
         fin = 1'b1;
         st  = ST_TRUNC;
      end

      emit             = fin || valid;
      rsp.out_byte     = valid ? item.in_byte : 8'd0;
      rsp.byte_valid   = valid;
      rsp.msg_end      = fin;
      rsp.status       = fin ? st : ST_OK;
      rsp.payload_len  = fin ? stepped.count : '0;

      nxt = item.in_last ? CTX_RESET : stepped;
   end

endmodule

/* hw/rtl/http_chunked_body_decoder.sv */
// Top level of the HTTP/1.1 chunked body decoder: input register, parser
// context, result register. Depends on chbd_pkg and chbd_step.
//
//   channel | ports                          | payload
//   --------+--------------------------------+-------------------------------
//   request | req_valid, req_ready, req_data | body byte, last-byte flag
//   result  | rsp_valid, rsp_ready, rsp_data | byte, flags, status, length
//
// One body byte per cycle sustained while the result side does not stall; a
// taken byte passes from the input register to the result register. The
// combinational context update in chbd_step sets the rate. Synchronous reset
// clears the valid flags and the parser context. A stalled result holds the
// result register; the input register then fills and req_ready drops until the result is taken.
module http_chunked_body_decoder
   import chbd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    in_vld_ff, in_vld_in;
   req_type in_data_ff, in_data_in;
   ctx_type ctx_ff, ctx_in;
   logic    rsp_vld_ff, rsp_vld_in;
   rsp_type rsp_data_ff, rsp_data_in;

   ctx_type step_nxt;
   logic    step_emit;
   rsp_type step_rsp;
   logic    advance;

   chbd_step u_step (
      .cur  (ctx_ff),
      .item (in_data_ff),
      .nxt  (step_nxt),
      .emit (step_emit),
      .rsp  (step_rsp)
   );

   // Process the held request once the result register is free or draining.
   assign advance   = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_data_in = in_data_ff;
      if (req_ready) begin
         in_vld_in  = req_valid;
         in_data_in = req_data;
      end
   end

   // Advance the parser context only when a request is consumed.
   assign ctx_in = advance ? step_nxt : ctx_ff;

   always_comb begin
      rsp_vld_in  = rsp_vld_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      if (advance) begin
         rsp_vld_in = step_emit;
         if (step_emit) rsp_data_in = step_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         ctx_ff     <= CTX_RESET;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         ctx_ff     <= ctx_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hw/rtl/chbd_checker.sv */
// Port-level checks for the chunked body decoder, bound to the top level.
// Depends on chbd_pkg.
module chbd_checker
   import chbd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_rsp_useful: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.byte_valid || rsp_data.msg_end)
      else $error("empty result");

   a_status_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.msg_end |->
         rsp_data.status == ST_OK && rsp_data.payload_len == '0)
      else $error("status without message end");

   a_byte_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.byte_valid |-> rsp_data.out_byte == 8'd0)
      else $error("stray payload byte");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status == ST_OK || rsp_data.status == ST_TRUNC ||
                    rsp_data.status == ST_OVF)
      else $error("bad status code");

endmodule

bind http_chunked_body_decoder chbd_checker u_chbd_checker (.*);
